[rtl/core/dcma_pkg.sv]
package dcma_pkg;

    // Default configuration of the filter
    localparam int TAPS_DEFAULT        = 8;
    localparam int SAMPLE_BITS_DEFAULT = 10;

    // Fixed widths of the stream fields
    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 10;
    localparam int SEL_W    = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Word kinds carried on s_tuser
    localparam logic REQ_TRIGGER = 1'b0;
    localparam logic REQ_SAMPLE  = 1'b1;

    // Converter input selector codes
    localparam logic [SEL_W-1:0] SEL_NONE = 3'd0;
    localparam logic [SEL_W-1:0] SEL_VOLT = 3'd6;
    localparam logic [SEL_W-1:0] SEL_TEMP = 3'd7;

    // Channel index into the sample memory
    localparam logic CH_TEMP = 1'b0;
    localparam logic CH_VOLT = 1'b1;

    // Conversion sequencer
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_TEMP = 3'b010,
        PH_VOLT = 3'b100
    } phase_t;

endpackage

[rtl/core/dual_channel_moving_average.sv]
// Channel | Ports                          | Contents of one word
// --------+--------------------------------+-------------------------------------------
// input   | s_tvalid s_tready s_tdata      | tuser: req_type; tdata: sample [9:0]
//         | s_tuser                        |
// result  | m_tvalid m_tready m_tdata      | tdata: temperature_avg [9:0],
//         |                                | voltage_avg [19:10], start_conversion [20],
//         |                                | input_select [23:21]
//
// One word per cycle while results are taken, one result word per input word;
// each word passes the memory read register, then the update into the output register.
// The rate is set by the single sample memory: one read port at accept, one
// write port at update; the two never touch the same entry for a sample word.
// Reset (aresetn low, synchronous) empties the pipeline, returns the sequencer
// to idle and clears position and totals; never-written ring entries read as zero
// through a lap flag, so no clearing pass is needed.
// A stalled result holds the update stage; input is still taken while that stage
// is free or draining.
module dual_channel_moving_average #(
    parameter int TAPS        = dcma_pkg::TAPS_DEFAULT,
    parameter int SAMPLE_BITS = dcma_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dcma_pkg::S_DATA_W-1:0] s_tdata,   // [9:0] sample, [15:10] zero
    input  logic                          s_tuser,   // [0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dcma_pkg::M_DATA_W-1:0] m_tdata    // [9:0] temperature_avg,
                                                     // [19:10] voltage_avg,
                                                     // [20] start_conversion,
                                                     // [23:21] input_select
);

    localparam int PW     = $clog2(TAPS);          // ring position bits
    localparam int AW     = PW + 1;                // channel bit on top
    localparam int DEPTH  = 2 ** AW;
    localparam int SB     = SAMPLE_BITS;
    localparam int TW     = SB + PW;               // running total bits
    localparam bit IS_POW2 = (TAPS & (TAPS - 1)) == 0;

    localparam logic [PW-1:0] POS_LAST = PW'(TAPS - 1);

    // ------------------------------------------------------------------
    // Accept stage: sequencer decision and memory read
    // ------------------------------------------------------------------
    dcma_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic             lapped_reg, lapped_next;

    logic             s_accept;
    logic             acc_push;
    logic             acc_ch;
    logic             acc_start;
    logic [dcma_pkg::SEL_W-1:0] acc_sel;
    logic [SB-1:0]    acc_value;
    logic [AW-1:0]    acc_addr;

    // Update stage
    logic             s1_valid_reg;
    logic             s1_push_reg;
    logic             s1_ch_reg;
    logic             s1_lapped_reg;
    logic             s1_start_reg;
    logic [dcma_pkg::SEL_W-1:0] s1_sel_reg;
    logic [SB-1:0]    s1_value_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_adv;

    // Sample memory: temperature ring in the lower half, voltage ring in the upper
    logic [SB-1:0]    ring_mem [DEPTH];
    logic [SB-1:0]    mem_q_reg;

    // Totals and output register
    logic [TW-1:0]    temp_total_reg;
    logic [TW-1:0]    volt_total_reg;
    logic [TW-1:0]    total_sel;
    logic [TW-1:0]    total_upd;
    logic [SB-1:0]    old_value;
    logic             m_valid_reg;
    logic             out_start_reg;
    logic [dcma_pkg::SEL_W-1:0] out_sel_reg;

    logic [SB-1:0]    temp_q;
    logic [SB-1:0]    volt_q;
    logic [dcma_pkg::AVG_W-1:0] temp_avg;
    logic [dcma_pkg::AVG_W-1:0] volt_avg;

    // Take the low SAMPLE_BITS of the converter word
    generate
        if (SB <= dcma_pkg::SAMPLE_W) begin : g_smp_cut
            assign acc_value = s_tdata[SB-1:0];
        end else begin : g_smp_ext
            assign acc_value = {{(SB - dcma_pkg::SAMPLE_W){1'b0}},
                                s_tdata[dcma_pkg::SAMPLE_W-1:0]};
        end
    endgenerate

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // Sequencer: trigger starts temperature, temperature sample starts voltage,
    // voltage sample advances the ring and goes idle; anything else is dropped
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        lapped_next = lapped_reg;
        acc_push    = 1'b0;
        acc_ch      = dcma_pkg::CH_TEMP;
        acc_start   = 1'b0;
        if (s_tuser == dcma_pkg::REQ_TRIGGER) begin
            if (phase_reg != dcma_pkg::PH_TEMP && phase_reg != dcma_pkg::PH_VOLT) begin
                phase_next = dcma_pkg::PH_TEMP;
                acc_start  = 1'b1;
            end
        end else begin
            case (phase_reg)
                dcma_pkg::PH_TEMP: begin
                    acc_push   = 1'b1;
                    acc_ch     = dcma_pkg::CH_TEMP;
                    acc_start  = 1'b1;
                    phase_next = dcma_pkg::PH_VOLT;
                end
                dcma_pkg::PH_VOLT: begin
                    acc_push   = 1'b1;
                    acc_ch     = dcma_pkg::CH_VOLT;
                    phase_next = dcma_pkg::PH_IDLE;
                    if (pos_reg == POS_LAST) begin
                        pos_next    = '0;
                        lapped_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (phase_next)
            dcma_pkg::PH_TEMP: acc_sel = dcma_pkg::SEL_TEMP;
            dcma_pkg::PH_VOLT: acc_sel = dcma_pkg::SEL_VOLT;
            default:           acc_sel = dcma_pkg::SEL_NONE;
        endcase
    end

    assign acc_addr = {acc_ch, pos_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= dcma_pkg::PH_IDLE;
            pos_reg    <= '0;
            lapped_reg <= 1'b0;
        end else if (s_accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            lapped_reg <= lapped_next;
        end
    end

    // Read the oldest entry of the channel while the word enters
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem_q_reg <= ring_mem[acc_addr];
        end
        if (s1_adv && s1_push_reg) begin
            ring_mem[s1_addr_reg] <= s1_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_push_reg   <= acc_push;
            s1_ch_reg     <= acc_ch;
            s1_lapped_reg <= lapped_reg;
            s1_start_reg  <= acc_start;
            s1_sel_reg    <= acc_sel;
            s1_value_reg  <= acc_value;
            s1_addr_reg   <= acc_addr;
        end
    end

    // ------------------------------------------------------------------
    // Update stage: correct the running total, load the output register
    // ------------------------------------------------------------------
    // Before the first lap completes the read entry was never written: use zero
    assign old_value = s1_lapped_reg ? mem_q_reg : '0;
    assign total_sel = (s1_ch_reg == dcma_pkg::CH_VOLT) ? volt_total_reg : temp_total_reg;
    assign total_upd = total_sel - TW'(old_value) + TW'(s1_value_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_total_reg <= '0;
            volt_total_reg <= '0;
        end else if (s1_adv && s1_push_reg) begin
            if (s1_ch_reg == dcma_pkg::CH_VOLT) begin
                volt_total_reg <= total_upd;
            end else begin
                temp_total_reg <= total_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_start_reg <= s1_start_reg;
            out_sel_reg   <= s1_sel_reg;
        end
    end

    // Totals only move when the output register loads, so the averages
    // are taken straight from them
    generate
        if (IS_POW2) begin : g_div_shift
            logic [TW-1:0] temp_sh;
            logic [TW-1:0] volt_sh;
            assign temp_sh = temp_total_reg >> PW;
            assign volt_sh = volt_total_reg >> PW;
            assign temp_q  = temp_sh[SB-1:0];
            assign volt_q  = volt_sh[SB-1:0];
        end else begin : g_div_recip
            // Multiply by the rounded-up reciprocal; exact for every TW-bit total
            localparam int          SH     = TW + PW;
            localparam logic [63:0] M_FULL = ((64'd1 << SH) + 64'(TAPS) - 64'd1) / 64'(TAPS);
            localparam logic [TW:0] RECIP  = M_FULL[TW:0];
            logic [2*TW:0] temp_prod;
            logic [2*TW:0] volt_prod;
            assign temp_prod = {{(TW + 1){1'b0}}, temp_total_reg} * {{TW{1'b0}}, RECIP};
            assign volt_prod = {{(TW + 1){1'b0}}, volt_total_reg} * {{TW{1'b0}}, RECIP};
            assign temp_q    = temp_prod[SH +: SB];
            assign volt_q    = volt_prod[SH +: SB];
        end
    endgenerate

    generate
        if (SB >= dcma_pkg::AVG_W) begin : g_avg_cut
            assign temp_avg = temp_q[dcma_pkg::AVG_W-1:0];
            assign volt_avg = volt_q[dcma_pkg::AVG_W-1:0];
        end else begin : g_avg_ext
            assign temp_avg = {{(dcma_pkg::AVG_W - SB){1'b0}}, temp_q};
            assign volt_avg = {{(dcma_pkg::AVG_W - SB){1'b0}}, volt_q};
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_sel_reg, out_start_reg, volt_avg, temp_avg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // The lap flag only sets as the ring position wraps to zero
    a_lap_on_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(lapped_reg) |-> pos_reg == '0)
        else $error("lap flag set without position wrap");

    // Read and write of the same entry never overlap for a sample word
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && acc_push && s1_valid_reg && s1_push_reg) |-> acc_addr != s1_addr_reg)
        else $error("sample memory read and write hit one entry");

    // A temperature update always launches the voltage conversion
    a_temp_starts_volt: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_push_reg && s1_ch_reg == dcma_pkg::CH_TEMP)
        |-> (s1_start_reg && s1_sel_reg == dcma_pkg::SEL_VOLT))
        else $error("temperature update did not start voltage conversion");

    // A started conversion always names a converter input
    a_start_has_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_start_reg) |-> out_sel_reg != dcma_pkg::SEL_NONE)
        else $error("conversion started with no input selected");

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dcma_pkg::*;

    // Timing of the run
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 5;
    localparam int TARGET_WORDS = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int HOLD_AFTER   = 60;     // results seen before the hold-off starts
    localparam int STALL_LIMIT  = 4000;   // cycles without any handshake
    localparam int MAX_WAIT     = 19;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // One input word: req_type travels on s_tuser, the sample on s_tdata
    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] sample;
    } word_t;

    // One result word, laid out exactly as m_tdata (lowest field last)
    typedef struct packed {
        logic [SEL_W-1:0] input_select;
        logic             start_conversion;
        logic [AVG_W-1:0] voltage_avg;
        logic [AVG_W-1:0] temperature_avg;
    } average_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = REQ_TRIGGER;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Stimulus waiting to be offered, and averages still owed by the block
    word_t    pending_words[$];
    average_t owed_averages[$];
    word_t    word_on_bus;

    // Own copy of the filter state: one ring, total and average per channel
    phase_t              seq_phase = PH_IDLE;
    logic [2:0]          ring_pos  = '0;
    logic [SAMPLE_W-1:0] ch_ring [2][TAPS_DEFAULT];
    logic [12:0]         ch_total [2];
    logic [AVG_W-1:0]    ch_avg [2];

    int failures     = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int send_wait    = 0;
    int recv_wait    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;

    dual_channel_moving_average u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [9:0] sample, [15:10] zero
        .s_tuser  (s_tuser),    // [0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [9:0] temperature_avg, [19:10] voltage_avg,
                                // [20] start_conversion, [23:21] input_select
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // Apply one accepted word to the sequencer and the boxcar filters and
    // return the result word the block must produce for it.
    function automatic average_t advance_filter(word_t w);
        average_t r;
        logic     start;
        logic     ch;
        start = 1'b0;
        if (w.req_type == REQ_TRIGGER) begin
            // A trigger only counts when no conversion is pending
            if (seq_phase != PH_TEMP && seq_phase != PH_VOLT) begin
                seq_phase = PH_TEMP;
                start     = 1'b1;
            end
        end else if (seq_phase == PH_TEMP || seq_phase == PH_VOLT) begin
            // Replace the oldest entry and correct the running total
            ch = (seq_phase == PH_TEMP) ? CH_TEMP : CH_VOLT;
            ch_total[ch] = ch_total[ch] - 13'(ch_ring[ch][ring_pos]) + 13'(w.sample);
            ch_ring[ch][ring_pos] = w.sample;
            ch_avg[ch] = AVG_W'(32'(ch_total[ch]) / TAPS_DEFAULT);
            if (ch == CH_TEMP) begin
                seq_phase = PH_VOLT;
                start     = 1'b1;
            end else begin
                // Both channels done: advance the shared position, back to idle
                ring_pos  = ring_pos + 3'd1;
                seq_phase = PH_IDLE;
            end
        end
        // A sample while idle falls through and leaves the state alone
        r.temperature_avg  = ch_avg[CH_TEMP];
        r.voltage_avg      = ch_avg[CH_VOLT];
        r.start_conversion = start;
        r.input_select     = (seq_phase == PH_TEMP) ? SEL_TEMP :
                             (seq_phase == PH_VOLT) ? SEL_VOLT : SEL_NONE;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Stretches with no idling alternate with stretches of random waits
    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Favor the sample extremes so full and empty rings both show up
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 30) return SAMPLE_MAX;
        return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
    endfunction

    task automatic add_word(logic req_type, logic [SAMPLE_W-1:0] sample);
        word_t w;
        w.req_type = req_type;
        w.sample   = sample;
        pending_words.push_back(w);
    endtask

    // Well-formed cycle: trigger, temperature sample, voltage sample
    task automatic add_conversion(logic [SAMPLE_W-1:0] temp, logic [SAMPLE_W-1:0] volt);
        add_word(REQ_TRIGGER, '0);
        add_word(REQ_SAMPLE, temp);
        add_word(REQ_SAMPLE, volt);
    endtask

    // Driver: offer pending words, hold each until the block takes it,
    // then wait the drawn number of cycles before the next.
    always @(posedge aclk) begin : driver
        logic offer;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= REQ_TRIGGER;
            send_wait = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                owed_averages.push_back(advance_filter(word_on_bus));
                words_sent++;
                offer     = 1'b0;
                send_wait = draw_wait(((words_sent / 50) % 3) == 0);
            end
            if (!offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_words.size() > 0) begin
                    word_on_bus = pending_words.pop_front();
                    s_tdata <= {{(S_DATA_W - SAMPLE_W){1'b0}}, word_on_bus.sample};
                    s_tuser <= word_on_bus.req_type;
                    offer   = 1'b1;
                end
            end
            // Single assignment: valid stays high across back-to-back words
            s_tvalid <= offer;
        end
    end

    // Monitor: take result words, check each against the oldest owed average,
    // then stall the drawn number of cycles.
    always @(posedge aclk) begin : monitor
        average_t got;
        average_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = average_t'(m_tdata);
                results_seen++;
                if (owed_averages.size() == 0) begin
                    $error("result word with no word pending: %h", m_tdata);
                    failures++;
                end else begin
                    want = owed_averages.pop_front();
                    check_field("temperature_avg", int'(want.temperature_avg),
                                int'(got.temperature_avg));
                    check_field("voltage_avg", int'(want.voltage_avg),
                                int'(got.voltage_avg));
                    check_field("start_conversion", int'(want.start_conversion),
                                int'(got.start_conversion));
                    check_field("input_select", int'(want.input_select),
                                int'(got.input_select));
                end
                recv_wait = draw_wait(((results_seen / 40) % 3) == 1);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_tready <= (recv_wait == 0) && (hold_left == 0);
        end
    end

    // Hold off the receiver once for a long stretch so the block backs up
    // and has to drop s_tready while the driver keeps offering.
    always @(posedge aclk) begin : hold_off
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int counted;
        int r;
        int k;
        logic [SAMPLE_W-1:0] level;
        foreach (ch_ring[c, t]) ch_ring[c][t] = '0;
        foreach (ch_total[c]) begin
            ch_total[c] = '0;
            ch_avg[c]   = '0;
        end

        // Directed: special cases of the sequencer, then drive both rings
        // toward full scale.
        add_word(REQ_SAMPLE, SAMPLE_MAX);     // sample while idle: dropped
        add_word(REQ_TRIGGER, '0);            // trigger from idle
        add_word(REQ_TRIGGER, SAMPLE_MAX);    // trigger while temperature pending
        add_word(REQ_SAMPLE, SAMPLE_MAX);     // temperature sample
        add_word(REQ_TRIGGER, '0);            // trigger while voltage pending
        add_word(REQ_SAMPLE, SAMPLE_MAX);     // voltage sample, back to idle
        add_word(REQ_SAMPLE, '0);             // sample while idle again
        for (k = 0; k < 6; k++) add_conversion(SAMPLE_MAX, SAMPLE_MAX);

        // Random: mostly well-formed cycles, with constant sweeps that fill or
        // empty whole rings, broken cycles and stray words.
        counted = 0;
        while (counted < TARGET_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                level = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                for (k = 0; k < TAPS_DEFAULT; k++) add_conversion(level, level);
                counted += 3 * TAPS_DEFAULT;
            end else if (r < 80) begin
                add_conversion(draw_sample(), draw_sample());
                counted += 3;
            end else if (r < 90) begin
                // Broken cycle: voltage sample never comes
                add_word(REQ_TRIGGER, '0);
                add_word(REQ_SAMPLE, draw_sample());
                counted += 2;
            end else begin
                add_word(1'($urandom_range(0, 1)), draw_sample());
                counted += 1;
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: everything offered, taken and answered
        while (pending_words.size() > 0 || s_tvalid || owed_averages.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
